[rtl/core/aecc_pkg.sv]
// Package for the ADC LSB entropy collector: job type, CRC constants and byte step.
`default_nettype none

package aecc_pkg;

  localparam int unsigned WordBits  = 32;
  localparam int unsigned CntBits   = $clog2(WordBits);
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrBits  = $clog2(QueueDepth);
  localparam int unsigned QCntBits  = $clog2(QueueDepth + 1);

  localparam logic [31:0] CrcPoly   = 32'hEDB8_8320;
  localparam logic [31:0] CrcInit   = 32'hFFFF_FFFF;
  localparam logic [31:0] CrcXorOut = 32'hFFFF_FFFF;

  // One unit of work handed from the front to the back.
  typedef struct packed {
    logic [WordBits-1:0] word;
    logic                err;
  } job_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CRC,
    ST_EMIT
  } back_state_e;

  // Reflected CRC-32 over one byte, eight bit steps.
  function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] data);
    logic [31:0] c;
    c = crc ^ {24'h0, data};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/core/aecc_front.sv]
// Front end: accept samples, gather LSBs into a word, hand finished words and errors to the queue.
`default_nettype none

module aecc_front
  import aecc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        sample_lsb_i,
  input  wire logic        sample_failed_i,
  input  wire logic        q_full_i,
  output logic             q_push_o,
  output job_t             q_job_o
);

  logic [WordBits-1:0] acc_q, acc_d;
  logic [CntBits-1:0]  cnt_q, cnt_d;
  logic [WordBits-1:0] acc_next;
  logic                accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    acc_next = acc_q | ({{(WordBits-1){1'b0}}, sample_lsb_i} << cnt_q);
    acc_d    = acc_q;
    cnt_d    = cnt_q;
    q_push_o = 1'b0;
    q_job_o  = '{word: acc_next, err: 1'b0};
    if (accept) begin
      if (sample_failed_i) begin
        // Drop the partial word and report.
        acc_d    = '0;
        cnt_d    = '0;
        q_push_o = 1'b1;
        q_job_o  = '{word: '0, err: 1'b1};
      end else if (cnt_q == CntBits'(WordBits - 1)) begin
        acc_d    = '0;
        cnt_d    = '0;
        q_push_o = 1'b1;
      end else begin
        acc_d = acc_next;
        cnt_d = cnt_q + CntBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      cnt_q <= '0;
    end else begin
      acc_q <= acc_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/aecc_queue.sv]
// Short job queue between front and back.
`default_nettype none

module aecc_queue
  import aecc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  job_t      push_job_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      empty_o,
  output job_t      head_o
);

  job_t                slot_q [QueueDepth];
  logic [QPtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntBits-1:0] cnt_q;

  assign full_o  = (cnt_q == QCntBits'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPtrBits'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPtrBits'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QCntBits'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QCntBits'(1);
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/aecc_back.sv]
// Back end: run CRC-32 a byte per cycle on queued words, drive the output register.
`default_nettype none

module aecc_back
  import aecc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        q_empty_i,
  input  job_t             q_head_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      out_word_o,
  output logic             out_err_o
);

  back_state_e   state_q, state_d;
  logic [1:0]    idx_q, idx_d;
  logic [31:0]   crc_q, crc_d;
  logic [31:0]   word_q, word_d;
  logic          vld_q, vld_d;
  logic [31:0]   oword_q, oword_d;
  logic          oerr_q, oerr_d;
  logic          out_free;

  assign out_free    = !vld_q || out_ready_i;
  assign out_valid_o = vld_q;
  assign out_word_o  = oword_q;
  assign out_err_o   = oerr_q;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    crc_d   = crc_q;
    word_d  = word_q;
    oword_d = oword_q;
    oerr_d  = oerr_q;
    vld_d   = vld_q && !out_ready_i;
    q_pop_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          if (q_head_i.err) begin
            // Errors skip the CRC and go straight out.
            if (out_free) begin
              q_pop_o = 1'b1;
              vld_d   = 1'b1;
              oword_d = '0;
              oerr_d  = 1'b1;
            end
          end else begin
            q_pop_o = 1'b1;
            word_d  = q_head_i.word;
            crc_d   = CrcInit;
            idx_d   = '0;
            state_d = ST_CRC;
          end
        end
      end
      ST_CRC: begin
        crc_d = crc_byte(crc_q, word_q[{idx_q, 3'b000} +: 8]);
        idx_d = idx_q + 2'd1;
        if (idx_q == 2'd3) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          vld_d   = 1'b1;
          oword_d = crc_q ^ CrcXorOut;
          oerr_d  = 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      vld_q   <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    crc_q   <= crc_d;
    word_q  <= word_d;
    oword_q <= oword_d;
    oerr_q  <= oerr_d;
  end

endmodule

`default_nettype wire

[rtl/core/adc_lsb_entropy_crc32_collector.sv]
// Top level of the ADC LSB entropy collector with CRC-32 whitening.
//
// Input channel (s_axis): one 12-bit ADC sample per item in tdata, the
// failed-read flag in tuser. Only bit 0 of the sample is kept.
// Output channel (m_axis): one CRC-32 word in tdata and the error flag in
// tuser, emitted after every 32 good samples in a row or for each failed sample.
//
// Throughput: one input item per cycle while the queue has room. The front
// end gathers bits and pushes a job into a four-entry queue; the back end
// runs the CRC one byte per cycle, so a word result passes from the queue
// through the four CRC steps and the emit state to the output register. An
// error result skips the CRC and goes from the queue to the output register.
// A word job holds the back end through its pop, CRC and emit states and an
// error job only for its pop, so failed samples that arrive back to back
// right after a completed word fill the queue and pull s_axis_tready_o low.
//
// Reset clears the bit count, accumulator, queue and output valid.
// When the receiver stalls, the output register holds its item, the back
// end waits, the queue fills, and s_axis_tready_o drops once it is full.
`default_nettype none

module adc_lsb_entropy_crc32_collector
  import aecc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i,   // [11:0] sample, [15:12] zero
  input  wire logic        s_axis_tuser_i,   // [0] sample_failed
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o,   // [31:0] random_word
  output logic             m_axis_tuser_o    // [0] error
);

  logic q_push, q_pop, q_full, q_empty;
  job_t push_job, head_job;

  // Front: accept and classify samples.
  aecc_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid_i),
    .in_ready_o      (s_axis_tready_o),
    .sample_lsb_i    (s_axis_tdata_i[0]),
    .sample_failed_i (s_axis_tuser_i),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_job_o         (push_job)
  );

  // Queue: decouple sample intake from CRC work and output stalls.
  aecc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_job_i (push_job),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .head_o     (head_job)
  );

  // Back: whiten words and present results.
  aecc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_head_i    (head_job),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_word_o  (m_axis_tdata_o),
    .out_err_o   (m_axis_tuser_o)
  );

endmodule

`default_nettype wire
